// ===== design/lba_pkg.sv =====
// Shared types, constants and command/status structs of the linked block allocator.
package lba_pkg;

    // Store geometry
    localparam int DISK_BLOCKS = 256;
    localparam int BLK_W       = 8;
    localparam int CNT_W       = 9;
    localparam int ENTRY_W     = BLK_W + 1;

    // Configuration port
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam logic REG_BLOCKS_IN_USE = 1'b0;
    localparam logic [CNT_W-1:0] BLOCKS_RESET = 9'd256;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_BAD_ARG  = 2'd2;

    typedef struct packed {
        logic             operation;
        logic [CNT_W-1:0] block_count;
        logic [BLK_W-1:0] start_block;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [BLK_W-1:0] first_block;
        logic [BLK_W-1:0] last_block;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] used_count;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       set_err;
        logic [1:0] err_code;
        logic       walk_begin;
        logic       walk_step;
        logic       scan_begin;
        logic       scan_step;
        logic       alloc_close;
        logic       load_rsp;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_free;
        logic chk_zero;
        logic chk_short;
        logic chk_bad;
        logic scan_last;
        logic walk_last;
    } stat_t;

endpackage

// ===== design/lba_datapath.sv =====
// Datapath: flag and link memories, counters, request and response registers.
module lba_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [lba_pkg::CNT_W-1:0]     cfg_blocks,
    output logic [lba_pkg::CNT_W-1:0]     blocks_in_use,
    input  lba_pkg::req_t                 req,
    input  lba_pkg::cmd_t                 cmd,
    output lba_pkg::stat_t                stat,
    output lba_pkg::rsp_t                 rsp
);

    logic [lba_pkg::CNT_W-1:0]       free_reg, free_next;
    logic [lba_pkg::CNT_W-1:0]       used_reg, used_next;
    logic [lba_pkg::CNT_W-1:0]       mark_reg, mark_next;
    logic [lba_pkg::CNT_W-1:0]       biu_reg;
    logic [lba_pkg::CNT_W-1:0]       managed_reg;
    logic [lba_pkg::CNT_W-1:0]       managed_new;

    logic                            op_reg;
    logic [lba_pkg::CNT_W-1:0]       want_reg;
    logic [lba_pkg::BLK_W-1:0]       start_reg;
    logic [lba_pkg::BLK_W-1:0]       idx_reg;
    logic [lba_pkg::CNT_W-1:0]       taken_reg;
    logic [lba_pkg::BLK_W-1:0]       prev_reg;
    logic                            have_prev_reg;
    logic [lba_pkg::BLK_W-1:0]       head_reg;
    logic [lba_pkg::BLK_W-1:0]       tail_reg;
    logic [lba_pkg::BLK_W-1:0]       cur_reg;
    logic [1:0]                      code_reg;
    lba_pkg::rsp_t                   rsp_reg;

    logic                            flag_mem [lba_pkg::DISK_BLOCKS];
    logic                            flag_rdata_reg;
    logic                            rd_valid_reg;
    logic                            flag_wr;
    logic [lba_pkg::BLK_W-1:0]       flag_addr;
    logic                            used_flag;

    logic [lba_pkg::ENTRY_W-1:0]     link_mem [lba_pkg::DISK_BLOCKS];
    logic [lba_pkg::ENTRY_W-1:0]     rdata_reg;
    logic [lba_pkg::BLK_W-1:0]       rd_addr;
    logic                            wr_en;
    logic [lba_pkg::ENTRY_W-1:0]     wr_data;

    logic                            found;
    logic                            walk_live;
    logic [lba_pkg::BLK_W-1:0]       link;
    logic                            link_end;

    // Managed size, limited to the store
    assign managed_new = (cfg_blocks > lba_pkg::CNT_W'(lba_pkg::DISK_BLOCKS))
                         ? lba_pkg::CNT_W'(lba_pkg::DISK_BLOCKS) : cfg_blocks;

    // Flags at or above the high-water mark were never set since the last clear
    assign used_flag = rd_valid_reg && flag_rdata_reg;
    assign found     = !used_flag;
    assign walk_live = used_flag;
    assign link      = rdata_reg[lba_pkg::BLK_W-1:0];
    assign link_end  = rdata_reg[lba_pkg::BLK_W];

    // Status toward the controller
    always_comb
    begin
        stat.op_free   = (op_reg == lba_pkg::OP_FREE);
        stat.chk_zero  = (want_reg == '0);
        stat.chk_short = (free_reg < want_reg);
        stat.chk_bad   = ({1'b0, start_reg} >= managed_reg) || !used_flag;
        stat.scan_last = found && ((taken_reg + 1'b1) == want_reg);
        stat.walk_last = !walk_live || link_end || ({1'b0, link} >= managed_reg)
                         || (link == cur_reg);
    end

    // Read address: scan runs one block ahead, walk follows the link just read
    always_comb
    begin
        if (cmd.walk_step)
        begin
            rd_addr = link;
        end
        else if (cmd.scan_step)
        begin
            rd_addr = idx_reg + 1'b1;
        end
        else if (cmd.scan_begin)
        begin
            rd_addr = idx_reg;
        end
        else if (cmd.load_req)
        begin
            rd_addr = req.start_block;
        end
        else
        begin
            rd_addr = start_reg;
        end
        flag_wr   = (cmd.scan_step && found) || (cmd.walk_step && walk_live);
        flag_addr = cmd.scan_step ? idx_reg : cur_reg;
        wr_en     = (cmd.scan_step && found && have_prev_reg) || cmd.alloc_close;
        wr_data   = cmd.alloc_close ? {1'b1, {lba_pkg::BLK_W{1'b0}}} : {1'b0, idx_reg};
    end

    always_ff @(posedge clk)
    begin
        if (flag_wr)
        begin
            flag_mem[flag_addr] <= cmd.scan_step;
        end
        if (wr_en)
        begin
            link_mem[prev_reg] <= wr_data;
        end
        flag_rdata_reg <= flag_mem[rd_addr];
        rd_valid_reg   <= ({1'b0, rd_addr} < mark_reg);
        rdata_reg      <= link_mem[rd_addr];
    end

    // Counters and high-water mark
    always_comb
    begin
        free_next = free_reg;
        used_next = used_reg;
        mark_next = mark_reg;
        if (cfg_wr)
        begin
            free_next = managed_new;
            used_next = '0;
            mark_next = '0;
        end
        else if (cmd.scan_step)
        begin
            if (found && ({1'b0, idx_reg} >= mark_reg))
            begin
                mark_next = {1'b0, idx_reg} + 1'b1;
            end
        end
        else if (cmd.alloc_close)
        begin
            free_next = free_reg - taken_reg;
            used_next = used_reg + taken_reg;
        end
        else if (cmd.walk_step && walk_live)
        begin
            free_next = free_reg + 1'b1;
            if (used_reg != '0)
            begin
                used_next = used_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg    <= lba_pkg::BLOCKS_RESET;
            used_reg    <= '0;
            mark_reg    <= '0;
            biu_reg     <= lba_pkg::BLOCKS_RESET;
            managed_reg <= lba_pkg::BLOCKS_RESET;
        end
        else
        begin
            free_reg <= free_next;
            used_reg <= used_next;
            mark_reg <= mark_next;
            if (cfg_wr)
            begin
                biu_reg     <= cfg_blocks;
                managed_reg <= managed_new;
            end
        end
    end

    // Request, scan and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg        <= req.operation;
            want_reg      <= req.block_count;
            start_reg     <= req.start_block;
            idx_reg       <= '0;
            taken_reg     <= '0;
            have_prev_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            code_reg      <= lba_pkg::STATUS_DONE;
        end
        if (cmd.set_err)
        begin
            code_reg <= cmd.err_code;
        end
        if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (found)
            begin
                if (!have_prev_reg)
                begin
                    head_reg <= idx_reg;
                end
                prev_reg      <= idx_reg;
                have_prev_reg <= 1'b1;
                taken_reg     <= taken_reg + 1'b1;
            end
        end
        if (cmd.alloc_close)
        begin
            tail_reg <= prev_reg;
        end
        if (cmd.walk_begin)
        begin
            cur_reg  <= start_reg;
            head_reg <= start_reg;
        end
        if (cmd.walk_step)
        begin
            if (walk_live)
            begin
                tail_reg <= cur_reg;
            end
            cur_reg <= link;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.status      <= code_reg;
            rsp_reg.first_block <= head_reg;
            rsp_reg.last_block  <= tail_reg;
            rsp_reg.free_count  <= free_reg;
            rsp_reg.used_count  <= used_reg;
        end
    end

    assign rsp           = rsp_reg;
    assign blocks_in_use = biu_reg;

endmodule

// ===== design/lba_controller.sv =====
// Controller: sequences checks, allocation scan, free walk and response handoff.
module lba_controller
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  lba_pkg::stat_t stat,
    output lba_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        ALLOC_SCAN,
        ALLOC_TAIL,
        FREE_WALK,
        FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = CHECK;
                end
            end
            CHECK:
            begin
                if (stat.op_free)
                begin
                    if (stat.chk_bad)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = lba_pkg::STATUS_BAD_ARG;
                        state_next   = FINISH;
                    end
                    else
                    begin
                        cmd.walk_begin = 1'b1;
                        state_next     = FREE_WALK;
                    end
                end
                else if (stat.chk_zero)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = lba_pkg::STATUS_BAD_ARG;
                    state_next   = FINISH;
                end
                else if (stat.chk_short)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = lba_pkg::STATUS_NO_SPACE;
                    state_next   = FINISH;
                end
                else
                begin
                    cmd.scan_begin = 1'b1;
                    state_next     = ALLOC_SCAN;
                end
            end
            ALLOC_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ALLOC_TAIL;
                end
            end
            ALLOC_TAIL:
            begin
                cmd.alloc_close = 1'b1;
                state_next      = FINISH;
            end
            FREE_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = FINISH;
                end
            end
            FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold the response valid until taken
    always_comb
    begin
        if (cmd.load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== design/linked_block_allocator_unit.sv =====
// Top level of the linked block allocator: register port, controller and datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------
//  request  | req_valid / req_ready | req  (operation, count, start)
//  response | rsp_valid / rsp_ready | rsp  (status, blocks, counts)
//  config   | psel/penable/pwrite   | paddr, pwdata, prdata
//
// One request at a time. Errors go from the check state to the final state, which loads the response register.
// Allocate scans the flags from block 0 up to the highest block taken: one flag read per cycle.
// Free walks the chain block by block and also reads the free block that stops a walk.
// Reset and a size write only clear a high-water mark; flags at or above it read as free.
// A held response does not block the next request; the next one waits in
// its final state until the response register is taken.
module linked_block_allocator_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lba_pkg::ADDR_W-1:0]  paddr,
    input  logic [lba_pkg::DATA_W-1:0]  pwdata,
    output logic [lba_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  lba_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output lba_pkg::rsp_t               rsp
);

    lba_pkg::cmd_t              cmd;
    lba_pkg::stat_t             stat;
    logic                       cfg_wr;
    logic [lba_pkg::CNT_W-1:0]  blocks_in_use;

    // Decode register writes and reads
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == lba_pkg::REG_BLOCKS_IN_USE);
    assign prdata = (paddr[2] == lba_pkg::REG_BLOCKS_IN_USE)
                    ? {{(lba_pkg::DATA_W-lba_pkg::CNT_W){1'b0}}, blocks_in_use}
                    : '0;

    lba_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lba_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_wr),
        .cfg_blocks    (pwdata[lba_pkg::CNT_W-1:0]),
        .blocks_in_use (blocks_in_use),
        .req           (req),
        .cmd           (cmd),
        .stat          (stat),
        .rsp           (rsp)
    );

endmodule

// ===== tb/sv/tb_linked_block_allocator_unit.sv =====
// Self-checking testbench of the linked block allocator: random and directed requests.
module tb_linked_block_allocator_unit;

    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int HOLD_CYCLES     = 600;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int DRAIN_CYCLES    = 300;

    // Chain store tracker: mirrors flags, links and counts, queues expected responses
    class block_chain_tracker;
        int unsigned managed;
        int unsigned free_total;
        int unsigned used_total;
        bit          used [lba_pkg::DISK_BLOCKS];
        bit          chain_end [lba_pkg::DISK_BLOCKS];
        bit          written [lba_pkg::DISK_BLOCKS];
        int unsigned link [lba_pkg::DISK_BLOCKS];
        logic [lba_pkg::BLK_W-1:0] chain_heads [$];
        lba_pkg::rsp_t pending [$];
        int          mismatches;

        function new();
            mismatches = 0;
            foreach (written[k])
            begin
                written[k] = 1'b0;
            end
            configure(lba_pkg::BLOCKS_RESET);
        endfunction

        // Resize the store and clear every in-use flag and count
        function void configure(int unsigned value);
            int unsigned size;
            size = value & 32'h1FF;
            managed = (size > lba_pkg::DISK_BLOCKS) ? lba_pkg::DISK_BLOCKS : size;
            foreach (used[k])
            begin
                used[k]      = 1'b0;
                link[k]      = 0;
                chain_end[k] = 1'b1;
            end
            free_total = managed;
            used_total = 0;
            chain_heads.delete();
        endfunction

        // Apply one accepted request and queue the response it should produce
        function void note_request(lba_pkg::req_t r);
            lba_pkg::rsp_t e;
            int unsigned want;
            int unsigned taken;
            int unsigned prev;
            int unsigned cur;
            int unsigned steps;
            bit          have_prev;
            e    = '0;
            want = r.block_count;
            if (r.operation == lba_pkg::OP_ALLOC)
            begin
                if (want == 0)
                    e.status = lba_pkg::STATUS_BAD_ARG;
                else if (free_total < want)
                    e.status = lba_pkg::STATUS_NO_SPACE;
                else
                begin
                    taken     = 0;
                    prev      = 0;
                    have_prev = 1'b0;
                    // take the lowest free blocks and link them in order
                    for (int k = 0; k < managed && taken < want; k++)
                    begin
                        if (!used[k])
                        begin
                            used[k]      = 1'b1;
                            chain_end[k] = 1'b1;
                            written[k]   = 1'b1;
                            if (have_prev)
                            begin
                                link[prev]      = k;
                                chain_end[prev] = 1'b0;
                            end
                            else
                                e.first_block = lba_pkg::BLK_W'(k);
                            prev      = k;
                            have_prev = 1'b1;
                            taken++;
                        end
                    end
                    e.last_block = lba_pkg::BLK_W'(prev);
                    free_total  -= taken;
                    used_total  += taken;
                    chain_heads.push_back(e.first_block);
                end
            end
            else
            begin
                cur = r.start_block;
                if (cur >= managed || !used[cur])
                    e.status = lba_pkg::STATUS_BAD_ARG;
                else
                begin
                    e.first_block = lba_pkg::BLK_W'(cur);
                    steps = 0;
                    // walk the chain until an end mark, a bad link or a free block
                    while (steps < managed)
                    begin
                        used[cur] = 1'b0;
                        free_total++;
                        if (used_total > 0)
                            used_total--;
                        e.last_block = lba_pkg::BLK_W'(cur);
                        steps++;
                        if (chain_end[cur])
                            break;
                        if (link[cur] >= managed)
                            break;
                        cur = link[cur];
                        if (!used[cur])
                            break;
                    end
                end
            end
            e.free_count = lba_pkg::CNT_W'(free_total);
            e.used_count = lba_pkg::CNT_W'(used_total);
            pending.push_back(e);
        endfunction

        // Compare a response with the oldest expectation
        function void check_response(lba_pkg::rsp_t got);
            lba_pkg::rsp_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status %0d first %0d last %0d free %0d used %0d",
                             got.status, got.first_block, got.last_block,
                             got.free_count, got.used_count);
            end
            else
            begin
                e = pending.pop_front();
                if (got.status !== e.status || got.first_block !== e.first_block ||
                    got.last_block !== e.last_block || got.free_count !== e.free_count ||
                    got.used_count !== e.used_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"response mismatch: expected status %0d first %0d last %0d ",
                                  "free %0d used %0d, got status %0d first %0d last %0d ",
                                  "free %0d used %0d"},
                                 e.status, e.first_block, e.last_block, e.free_count,
                                 e.used_count, got.status, got.first_block, got.last_block,
                                 got.free_count, got.used_count);
                end
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lba_pkg::ADDR_W-1:0]  paddr;
    logic [lba_pkg::DATA_W-1:0]  pwdata;
    logic [lba_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        req_valid;
    logic                        req_ready;
    lba_pkg::req_t               req;
    logic                        rsp_valid;
    logic                        rsp_ready;
    lba_pkg::rsp_t               rsp;

    block_chain_tracker  tracker;
    int                  burst_left = 0;
    bit                  hold_request = 1'b0;
    int unsigned         cycle_count = 0;

    linked_block_allocator_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one request after an optional gap, hold it until accepted
    task automatic send_request(input lba_pkg::req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        tracker.note_request(r);
    endtask

    task automatic issue(input logic op, input int unsigned count, input int unsigned start);
        lba_pkg::req_t r;
        r.operation   = op;
        r.block_count = lba_pkg::CNT_W'(count);
        r.start_block = lba_pkg::BLK_W'(start);
        send_request(r);
    endtask

    // Drop valid and wait until every expected response has come back
    task automatic settle();
        req_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the store size over the register port while the block is idle
    task automatic apply_size(input int unsigned value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lba_pkg::ADDR_W'(lba_pkg::REG_BLOCKS_IN_USE) << 2;
        pwdata  <= lba_pkg::DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.configure(value);
    endtask

    // Mostly well-formed allocate/free traffic with some malformed requests mixed in
    function automatic lba_pkg::req_t pick_request();
        lba_pkg::req_t r;
        int unsigned roll;
        int unsigned lim;
        int unsigned off;
        int unsigned k;
        bit          found;
        r.operation   = lba_pkg::OP_ALLOC;
        r.block_count = lba_pkg::CNT_W'($urandom_range(0, 511));
        r.start_block = lba_pkg::BLK_W'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll >= 85)
        begin
            case ($urandom_range(0, 2))
                0: r.block_count = '0;
                1: r.block_count = lba_pkg::CNT_W'($urandom_range(tracker.free_total + 1, 511));
                default:
                begin
                    // never start a walk at a link entry that was never written
                    if (tracker.written[r.start_block])
                        r.operation = lba_pkg::OP_FREE;
                    else
                        r.block_count = '0;
                end
            endcase
        end
        else
        begin
            if (roll >= 45)
            begin
                found = 1'b0;
                if (tracker.chain_heads.size() != 0 && $urandom_range(0, 4) < 3)
                begin
                    k = $urandom_range(0, tracker.chain_heads.size() - 1);
                    r.start_block = tracker.chain_heads[k];
                    tracker.chain_heads.delete(k);
                    found = 1'b1;
                end
                else
                begin
                    // pick any block in use, possibly inside a chain
                    off = $urandom_range(0, 255);
                    for (int i = 0; i < tracker.managed && !found; i++)
                    begin
                        k = (off + i) % tracker.managed;
                        if (tracker.used[k])
                        begin
                            r.start_block = lba_pkg::BLK_W'(k);
                            found = 1'b1;
                        end
                    end
                end
                if (found)
                    r.operation = lba_pkg::OP_FREE;
            end
            if (r.operation == lba_pkg::OP_ALLOC)
            begin
                lim = (tracker.free_total > 12) ? 12 : tracker.free_total;
                if (lim == 0)
                    r.block_count = lba_pkg::CNT_W'(1);
                else if ($urandom_range(0, 9) == 0)
                    r.block_count = lba_pkg::CNT_W'($urandom_range(1, tracker.free_total));
                else
                    r.block_count = lba_pkg::CNT_W'($urandom_range(1, lim));
            end
        end
        return r;
    endfunction

    // Stimulus
    initial
    begin
        int unsigned phase_sizes [0:5];
        phase_sizes = '{256, 37, 2, 511, 1, 200};
        tracker   = new();
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full store: zero count, whole store, no space, frees at the tail and inside
        issue(lba_pkg::OP_ALLOC, 0, 0);
        issue(lba_pkg::OP_ALLOC, 256, 255);
        issue(lba_pkg::OP_ALLOC, 1, 0);
        issue(lba_pkg::OP_ALLOC, 300, 0);
        issue(lba_pkg::OP_FREE, 511, 255);
        issue(lba_pkg::OP_FREE, 0, 128);
        issue(lba_pkg::OP_FREE, 0, 128);
        issue(lba_pkg::OP_ALLOC, 3, 0);
        // walk runs on into the chain that reused the freed blocks
        issue(lba_pkg::OP_FREE, 0, 0);
        issue(lba_pkg::OP_ALLOC, 256, 0);
        issue(lba_pkg::OP_FREE, 0, 0);
        issue(lba_pkg::OP_FREE, 0, 7);

        // single managed block, start outside the managed size
        apply_size(1);
        issue(lba_pkg::OP_ALLOC, 1, 0);
        issue(lba_pkg::OP_ALLOC, 1, 0);
        issue(lba_pkg::OP_FREE, 0, 200);
        issue(lba_pkg::OP_FREE, 0, 0);

        // no managed blocks
        apply_size(0);
        issue(lba_pkg::OP_ALLOC, 1, 0);
        issue(lba_pkg::OP_FREE, 0, 0);
        issue(lba_pkg::OP_ALLOC, 0, 0);

        // oversize value is limited to the whole store
        apply_size(511);
        issue(lba_pkg::OP_ALLOC, 255, 0);
        issue(lba_pkg::OP_ALLOC, 2, 0);
        issue(lba_pkg::OP_ALLOC, 1, 0);
        issue(lba_pkg::OP_FREE, 0, 254);

        // random phases over several store sizes
        foreach (phase_sizes[p])
        begin
            apply_size(phase_sizes[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 0 && i == 60)
                    hold_request = 1'b1;
                if (p == 2 && i == 100)
                    settle();
                send_request(pick_request());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Response side: own stall pattern, one long hold-off on request
    initial
    begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(32, 160);
                end
                span--;
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ((span % 20) < 8);
                endcase
            end
        end
    end

    // Check accepted responses, bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else if (rst_n && rsp_valid && rsp_ready)
            tracker.check_response(rsp);
    end

endmodule
